>>> hdl/gaw_pkg.sv
// Package for the whitened advantage estimation block.
// Holds field widths, register index codes, fixed constants and the saturation helper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gaw_pkg;

    localparam int BATCH_DEPTH_DEF = 64;
    localparam int DATA_WIDTH_DEF  = 32;
    localparam int FIELD_W         = 32;
    localparam int CFG_W           = 17;
    localparam int CFG_IDX_W       = 2;
    localparam int ONE_Q16         = 65536;
    localparam int EPS_UNITS       = 43;
    localparam int MEM_W           = 2 * FIELD_W;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACE_DECAY = 2'd1;

    // Saturate a wide signed value to a signed range of sat_bits bits, returned as 32 bits.
    function automatic logic signed [FIELD_W-1:0] sat32(input logic signed [63:0] x,
                                                        input int sat_bits);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        logic signed [63:0] y;
        hi = (64'sd1 <<< (sat_bits - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (x > hi)
        begin
            y = hi;
        end
        else if (x < lo)
        begin
            y = lo;
        end
        else
        begin
            y = x;
        end
        return y[FIELD_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> hdl/gaw_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module gaw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> hdl/gaw_div.sv
// Iterative restoring unsigned divider, one quotient bit per cycle.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module gaw_div #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] dividend,
    input  wire logic [DEN_W-1:0] divisor,
    output logic                  done,
    output logic      [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   rem_shift;
    logic             fits;

    // One shift and trial subtraction per cycle.
    assign rem_shift = {rem_reg, quo_reg[NUM_W-1]};
    assign fits      = rem_shift >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(NUM_W);
            quo_reg  <= dividend;
            rem_reg  <= '0;
            den_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= DEN_W'(rem_shift - {1'b0, den_reg});
                quo_reg <= {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift[DEN_W-1:0];
                quo_reg <= {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

>>> hdl/gaw_isqrt.sv
// Iterative integer square root of a 64-bit value, one root bit per cycle.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module gaw_isqrt (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] radicand,
    output logic             done,
    output logic      [31:0] root
);

    logic [63:0] x_reg;
    logic [63:0] r_reg;
    logic [63:0] b_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [63:0] trial;

    assign trial = r_reg + b_reg;

    // Digit-by-digit root: one compare and subtract each cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd32;
            x_reg    <= radicand;
            r_reg    <= '0;
            b_reg    <= 64'h4000_0000_0000_0000;
        end
        else if (busy_reg)
        begin
            if (x_reg >= trial)
            begin
                x_reg <= x_reg - trial;
                r_reg <= (r_reg >> 1) + b_reg;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
            b_reg   <= b_reg >> 2;
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == 6'd1)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign done = done_reg;
    assign root = r_reg[31:0];

endmodule

`default_nettype wire

>>> hdl/gae_advantage_whitened_unit.sv
// Each item goes through the accept, discount multiply, recurrence update with store write,
// and square accumulate states in turn; the next item is taken only after that.
// At batch end the mean divide and the variance divide run on the shared divider, then the root;
// a degenerate batch skips these. Each result then needs a store read and, outside a degenerate
// batch, a divide on the shared divider, and is held while the output stalls.
// Reset clears the running values, accumulators and counts; store contents stay undefined.
`timescale 1ns / 1ps
`default_nettype none

module gae_advantage_whitened_unit
    import gaw_pkg::*;
#(
    parameter int BATCH_DEPTH = BATCH_DEPTH_DEF,
    parameter int DATA_WIDTH  = DATA_WIDTH_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [CFG_W-1:0]          cfg_data,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic signed [FIELD_W-1:0] reward,
    input  wire logic signed [FIELD_W-1:0] critic_value,
    input  wire logic                      valid_req,
    input  wire logic                      row_start,
    input  wire logic                      batch_end,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic signed [FIELD_W-1:0]      whitened_advantage,
    output logic signed [FIELD_W-1:0]      return_value,
    output logic                           degenerate,
    output logic                           last
);

    localparam int SAT_BITS = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
    localparam int AW       = (BATCH_DEPTH > 1) ? $clog2(BATCH_DEPTH) : 1;
    localparam int CW       = $clog2(BATCH_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_UPD, S_SQ, S_MEAN_W, S_MS, S_VAR, S_VAR_W,
        S_SQRT_W, S_RD, S_DATA, S_DIV_W, S_PUT
    } state_t;

    state_t state_reg;

    // Configuration and derived factors.
    logic [CFG_W-1:0] discount_reg;
    logic [CFG_W-1:0] decay_reg;
    logic [CFG_W-1:0] g_reg;
    logic [CFG_W-1:0] gl_reg;
    logic [CFG_W-1:0] g_next;
    logic [CFG_W-1:0] l_eff;
    logic [33:0]      gl_prod;

    // Token registers and running state.
    logic signed [FIELD_W-1:0] r_reg;
    logic signed [FIELD_W-1:0] v_reg;
    logic                      m_reg;
    logic                      be_reg;
    logic signed [FIELD_W-1:0] nxt_reg;
    logic signed [FIELD_W-1:0] adv_reg;
    logic signed [49:0]        pg_reg;
    logic signed [49:0]        pl_reg;
    logic [FIELD_W-1:0]        a_reg;
    logic signed [39:0]        sum_reg;
    logic [63:0]               sq_reg;
    logic [CW-1:0]             mcnt_reg;
    logic [CW-1:0]             fill_reg;

    // Whitening statistics.
    logic [31:0]        mm_reg;
    logic signed [32:0] mean_reg;
    logic [55:0]        mshi_reg;
    logic [47:0]        mslo_reg;
    logic [31:0]        sd_reg;
    logic [CW-1:0]      k_reg;
    logic               neg_reg;
    logic [FIELD_W-1:0] ret_hold_reg;

    // Shared unit handshakes.
    logic        div_go_reg;
    logic [63:0] div_num_reg;
    logic [31:0] div_den_reg;
    logic        div_done;
    logic [63:0] div_quo;
    logic        sqrt_go_reg;
    logic [63:0] sqrt_in_reg;
    logic        sqrt_done;
    logic [31:0] sqrt_root;

    // Output registers.
    logic                      out_valid_reg;
    logic signed [FIELD_W-1:0] wa_reg;
    logic signed [FIELD_W-1:0] rv_reg;
    logic                      degen_out_reg;
    logic                      last_reg;

    // Store port.
    logic          mem_we;
    logic [MEM_W-1:0] mem_wdata;
    logic [MEM_W-1:0] mem_rdata;

    // Factor clamp and the combined discount product.
    always_comb
    begin
        g_next  = (discount_reg > CFG_W'(ONE_Q16)) ? CFG_W'(ONE_Q16) : discount_reg;
        l_eff   = (decay_reg > CFG_W'(ONE_Q16)) ? CFG_W'(ONE_Q16) : decay_reg;
        gl_prod = 34'(g_next) * 34'(l_eff) + 34'd32768;
    end

    // Recurrence arithmetic for the update step.
    logic signed [49:0]        tg;
    logic signed [49:0]        tl;
    logic signed [63:0]        cand_w;
    logic signed [FIELD_W-1:0] cand;
    logic signed [FIELD_W-1:0] adv_new;
    logic signed [FIELD_W-1:0] ret_new;
    logic signed [49:0]        pg_next;
    logic signed [49:0]        pl_next;

    always_comb
    begin
        pg_next = nxt_reg * $signed({1'b0, g_reg});
        pl_next = adv_reg * $signed({1'b0, gl_reg});
        tg      = pg_reg + 50'sd32768;
        tl      = pl_reg + 50'sd32768;
        cand_w  = 64'(r_reg) + 64'($signed(tg[49:16])) - 64'(v_reg)
                + 64'($signed(tl[49:16]));
        cand    = sat32(cand_w, SAT_BITS);
        adv_new = m_reg ? cand : adv_reg;
        ret_new = sat32(64'(adv_new) + 64'(v_reg), SAT_BITS);
    end

    // Batch statistics arithmetic.
    logic [39:0]        sum_mag;
    logic [63:0]        ms;
    logic [63:0]        c2;
    logic [63:0]        var_cap;
    logic               degen;
    logic signed [33:0] cen;
    logic [33:0]        cen_mag;
    logic [63:0]        q_cap;
    logic signed [63:0] q_signed;
    logic               batch_done;

    always_comb
    begin
        sum_mag    = sum_reg[39] ? 40'(-sum_reg) : 40'(sum_reg);
        ms         = 64'(mshi_reg) + 64'(mslo_reg >> 16);
        c2         = (sq_reg > ms) ? (sq_reg - ms) : 64'd0;
        var_cap    = (div_quo > (64'd1 << 47)) ? (64'd1 << 47) : div_quo;
        degen      = mcnt_reg < CW'(2);
        cen        = 34'($signed(mem_rdata[MEM_W-1:FIELD_W])) - 34'(mean_reg);
        cen_mag    = cen[33] ? 34'(-cen) : 34'(cen);
        q_cap      = (div_quo > (64'd1 << 40)) ? (64'd1 << 40) : div_quo;
        q_signed   = neg_reg ? -$signed(q_cap) : $signed(q_cap);
        batch_done = be_reg || (fill_reg >= CW'(BATCH_DEPTH));
    end

    assign mem_we    = (state_reg == S_UPD);
    assign mem_wdata = {adv_new, ret_new};

    // Sequencer: token recurrence, batch statistics and the output walk.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            discount_reg  <= CFG_W'(ONE_Q16);
            decay_reg     <= CFG_W'(ONE_Q16);
            g_reg         <= CFG_W'(ONE_Q16);
            gl_reg        <= CFG_W'(ONE_Q16);
            nxt_reg       <= '0;
            adv_reg       <= '0;
            sum_reg       <= '0;
            sq_reg        <= '0;
            mcnt_reg      <= '0;
            fill_reg      <= '0;
            k_reg         <= '0;
            div_go_reg    <= 1'b0;
            sqrt_go_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            div_go_reg  <= 1'b0;
            sqrt_go_reg <= 1'b0;
            g_reg       <= g_next;
            gl_reg      <= gl_prod[32:16];

            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_DISCOUNT:    discount_reg <= cfg_data;
                    CFG_TRACE_DECAY: decay_reg    <= cfg_data;
                    default:         ;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        r_reg  <= reward;
                        v_reg  <= critic_value;
                        m_reg  <= valid_req;
                        be_reg <= batch_end;
                        if (row_start)
                        begin
                            nxt_reg <= '0;
                            adv_reg <= '0;
                        end
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    pg_reg    <= pg_next;
                    pl_reg    <= pl_next;
                    state_reg <= S_UPD;
                end
                S_UPD:
                begin
                    if (m_reg)
                    begin
                        nxt_reg  <= v_reg;
                        adv_reg  <= cand;
                        sum_reg  <= sum_reg + 40'(cand);
                        mcnt_reg <= mcnt_reg + 1'b1;
                        a_reg    <= cand[FIELD_W-1] ? FIELD_W'(-64'(cand)) : FIELD_W'(cand);
                    end
                    fill_reg  <= fill_reg + 1'b1;
                    state_reg <= S_SQ;
                end
                S_SQ:
                begin
                    if (m_reg)
                    begin
                        sq_reg <= sq_reg + ((64'(a_reg) * 64'(a_reg)) >> 16);
                    end
                    if (!batch_done)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (degen)
                    begin
                        k_reg     <= '0;
                        state_reg <= S_RD;
                    end
                    else
                    begin
                        div_num_reg <= 64'(sum_mag) + 64'(mcnt_reg >> 1);
                        div_den_reg <= 32'(mcnt_reg);
                        div_go_reg  <= 1'b1;
                        state_reg   <= S_MEAN_W;
                    end
                end
                S_MEAN_W:
                begin
                    if (div_done)
                    begin
                        mm_reg    <= div_quo[31:0];
                        state_reg <= S_MS;
                    end
                end
                S_MS:
                begin
                    mshi_reg  <= 56'(mm_reg) * 56'(sum_mag[39:16]);
                    mslo_reg  <= 48'(mm_reg) * 48'(sum_mag[15:0]);
                    mean_reg  <= sum_reg[39] ? -$signed({1'b0, mm_reg}) : $signed({1'b0, mm_reg});
                    state_reg <= S_VAR;
                end
                S_VAR:
                begin
                    div_num_reg <= c2;
                    div_den_reg <= 32'(mcnt_reg - 1'b1);
                    div_go_reg  <= 1'b1;
                    state_reg   <= S_VAR_W;
                end
                S_VAR_W:
                begin
                    if (div_done)
                    begin
                        sqrt_in_reg <= {var_cap[47:0], 16'd0} + 64'(EPS_UNITS);
                        sqrt_go_reg <= 1'b1;
                        state_reg   <= S_SQRT_W;
                    end
                end
                S_SQRT_W:
                begin
                    if (sqrt_done)
                    begin
                        sd_reg    <= sqrt_root;
                        k_reg     <= '0;
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    state_reg <= S_DATA;
                end
                S_DATA:
                begin
                    ret_hold_reg <= mem_rdata[FIELD_W-1:0];
                    if (degen)
                    begin
                        wa_reg        <= '0;
                        rv_reg        <= $signed(mem_rdata[FIELD_W-1:0]);
                        degen_out_reg <= 1'b1;
                        last_reg      <= (k_reg + 1'b1) == fill_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_PUT;
                    end
                    else
                    begin
                        neg_reg     <= cen[33];
                        div_num_reg <= 64'({cen_mag, 16'd0}) + 64'(sd_reg >> 1);
                        div_den_reg <= sd_reg;
                        div_go_reg  <= 1'b1;
                        state_reg   <= S_DIV_W;
                    end
                end
                S_DIV_W:
                begin
                    if (div_done)
                    begin
                        wa_reg        <= sat32(q_signed, SAT_BITS);
                        rv_reg        <= $signed(ret_hold_reg);
                        degen_out_reg <= 1'b0;
                        last_reg      <= (k_reg + 1'b1) == fill_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_PUT;
                    end
                end
                S_PUT:
                begin
                    if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        if (last_reg)
                        begin
                            nxt_reg   <= '0;
                            adv_reg   <= '0;
                            sum_reg   <= '0;
                            sq_reg    <= '0;
                            mcnt_reg  <= '0;
                            fill_reg  <= '0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= S_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Buffer for advantages and returns.
    gaw_ram #(
        .WIDTH (MEM_W),
        .DEPTH (BATCH_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (fill_reg[AW-1:0]),
        .wdata (mem_wdata),
        .raddr (k_reg[AW-1:0]),
        .rdata (mem_rdata)
    );

    // Shared divider for the mean, the variance and each scaled output.
    gaw_div #(
        .NUM_W (64),
        .DEN_W (32)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_go_reg),
        .dividend (div_num_reg),
        .divisor  (div_den_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Root of the variance plus epsilon.
    gaw_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_go_reg),
        .radicand (sqrt_in_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    assign in_stall           = (state_reg != S_IDLE);
    assign out_valid          = out_valid_reg;
    assign whitened_advantage = wa_reg;
    assign return_value       = rv_reg;
    assign degenerate         = degen_out_reg;
    assign last               = last_reg;

endmodule

`default_nettype wire
